FILE: sv/isqrt_pkg.sv
// Package: widths and the per-stage data type for the square root cell chain.
package isqrt_pkg;

    localparam int RADICAND_BITS = 31;
    localparam int ROOT_BITS     = (RADICAND_BITS + 1) / 2;
    localparam int PAD_BITS      = 2 * ROOT_BITS;
    localparam int REM_BITS      = ROOT_BITS + 1;
    localparam int STAGES        = ROOT_BITS;

    typedef struct packed {
        logic [PAD_BITS-1:0]  rad;
        logic [REM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] root;
    } isqrt_data_t;

endpackage

FILE: sv/isqrt_cell.sv
// One cell of the chain: resolves one root bit from the next two radicand bits.
module isqrt_cell
    import isqrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  isqrt_data_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output isqrt_data_t out_data
);

    logic        valid_reg;
    logic        valid_next;
    isqrt_data_t data_reg;
    isqrt_data_t data_next;

    logic [REM_BITS+1:0]  rem_shift;
    logic [REM_BITS+1:0]  trial;
    logic [REM_BITS+1:0]  diff;
    logic                 take;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        rem_shift = {in_data.rem, in_data.rad[PAD_BITS-1 -: 2]};
        trial     = (REM_BITS + 2)'({in_data.root, 2'b01});
        diff      = rem_shift - trial;
        take      = (rem_shift >= trial);

        data_next.rad  = PAD_BITS'({in_data.rad, 2'b00});
        data_next.rem  = take ? REM_BITS'(diff) : REM_BITS'(rem_shift);
        data_next.root = ROOT_BITS'({in_data.root, take});

        if (in_ready)
        begin
            valid_next = in_valid;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.rem <= {data_reg.root, 1'b0}))
        else $error("remainder exceeds twice the partial root");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("stalled cell lost or changed its transaction");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg)
        else $error("accepted transaction not captured");

endmodule

FILE: sv/isqrt_binary_search.sv
// Top level: floor square root of a radicand through a chain of one-bit cells.
//
//  channel    direction  handshake                    payload
//  radicand   in         radicand_valid/radicand_ready radicand [30:0]
//  root       out        root_valid/root_ready         root     [15:0]
//
//  One cell per root bit; the last cell register drives root. Each cell holds one
//  transaction, so up to 16 are in flight and one enters per cycle unless stalled.
//  A cell advances when empty or when the next cell takes its transaction; a stall
//  at root_ready backs up cell by cell and bubbles close up behind it.
//  Reset clears the cell valid bits only.
module isqrt_binary_search
    import isqrt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     radicand_valid,
    output logic                     radicand_ready,
    input  logic [RADICAND_BITS-1:0] radicand,
    output logic                     root_valid,
    input  logic                     root_ready,
    output logic [ROOT_BITS-1:0]     root
);

    logic        valid_chain [STAGES+1];
    logic        ready_chain [STAGES+1];
    isqrt_data_t data_chain  [STAGES+1];

    assign valid_chain[0]     = radicand_valid;
    assign radicand_ready     = ready_chain[0];
    assign data_chain[0].rad  = PAD_BITS'(radicand);
    assign data_chain[0].rem  = '0;
    assign data_chain[0].root = '0;

    genvar i;
    generate
        for (i = 0; i < STAGES; i++)
        begin : g_cell
            isqrt_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (valid_chain[i]),
                .in_ready  (ready_chain[i]),
                .in_data   (data_chain[i]),
                .out_valid (valid_chain[i+1]),
                .out_ready (ready_chain[i+1]),
                .out_data  (data_chain[i+1])
            );
        end
    endgenerate

    assign ready_chain[STAGES] = root_ready;
    assign root_valid          = valid_chain[STAGES];
    assign root                = data_chain[STAGES].root;

endmodule

FILE: tb/isqrt_binary_search_tb.sv
// Testbench for isqrt_binary_search: directed table and random radicands against a predictor.
`timescale 1ns / 1ps

module isqrt_binary_search_tb;
    import isqrt_pkg::*;

    localparam int RANDOM_COUNT   = 1600;
    localparam int QUIET_COUNT    = 150;
    localparam int HOLD_OFF_LEN   = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int DIRECTED_COUNT = 21;

    localparam logic [RADICAND_BITS-1:0] RADICAND_MAX = {RADICAND_BITS{1'b1}};

    typedef struct packed {
        logic [RADICAND_BITS-1:0] value;
        logic                     known;
        logic [ROOT_BITS-1:0]     root;
    } sqrt_case_t;

    logic                     clk;
    logic                     rst_n;
    logic                     radicand_valid;
    logic                     radicand_ready;
    logic [RADICAND_BITS-1:0] radicand;
    logic                     root_valid;
    logic                     root_ready;
    logic [ROOT_BITS-1:0]     root;

    logic [ROOT_BITS-1:0] root_expected_q[$];
    int                   error_count;
    int                   roots_checked;
    int                   idle_cycles;
    bit                   quiet_phase;
    bit                   hold_off_req;
    bit                   hold_off_done;

    sqrt_case_t directed_cases [DIRECTED_COUNT] = '{
        '{31'd0,          1'b1, 16'd0},
        '{31'd1,          1'b1, 16'd1},
        '{31'd2,          1'b1, 16'd1},
        '{31'd3,          1'b1, 16'd1},
        '{31'd4,          1'b1, 16'd2},
        '{31'd8,          1'b1, 16'd2},
        '{31'd9,          1'b1, 16'd3},
        '{31'd15,         1'b1, 16'd3},
        '{31'd16,         1'b1, 16'd4},
        '{RADICAND_MAX,   1'b1, 16'd46340},
        '{31'd2147395600, 1'b1, 16'd46340},
        '{31'd2147395599, 1'b1, 16'd46339},
        '{31'd2147395601, 1'b1, 16'd46340},
        '{31'h4000_0000,  1'b1, 16'd32768},
        '{31'h3FFF_FFFF,  1'b1, 16'd32767},
        '{31'h5555_5555,  1'b0, 16'd0},
        '{31'h2AAA_AAAA,  1'b0, 16'd0},
        '{31'h4000_0001,  1'b0, 16'd0},
        '{31'h1234_5678,  1'b0, 16'd0},
        '{31'h00FF_FFFF,  1'b0, 16'd0},
        '{31'd65535,      1'b0, 16'd0}
    };

    isqrt_binary_search u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .radicand_valid (radicand_valid),
        .radicand_ready (radicand_ready),
        .radicand       (radicand),
        .root_valid     (root_valid),
        .root_ready     (root_ready),
        .root           (root)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [ROOT_BITS-1:0] floor_root_of(input logic [RADICAND_BITS-1:0] value);
        logic [63:0] rem_acc;
        logic [63:0] root_acc;
        logic [63:0] probe;
        rem_acc  = 64'(value);
        root_acc = 64'd0;
        probe    = 64'd1 << 62;
        while (probe > rem_acc)
            probe = probe >> 2;
        while (probe != 64'd0)
        begin
            if (rem_acc >= root_acc + probe)
            begin
                rem_acc  = rem_acc - (root_acc + probe);
                root_acc = (root_acc >> 1) + probe;
            end
            else
            begin
                root_acc = root_acc >> 1;
            end
            probe = probe >> 2;
        end
        return root_acc[ROOT_BITS-1:0];
    endfunction

    function automatic logic [RADICAND_BITS-1:0] pick_radicand();
        int unsigned kind;
        logic [63:0] k;
        logic [63:0] sq;
        kind = $urandom_range(0, 9);
        case (kind)
            4, 5:
            begin
                k  = 64'($urandom_range(1, 46340));
                sq = k * k;
                case ($urandom_range(0, 2))
                    0:       sq = sq - 64'd1;
                    1:       sq = sq + 64'd1;
                    default: sq = sq;
                endcase
                return sq[RADICAND_BITS-1:0];
            end
            6:       return RADICAND_BITS'($urandom_range(0, 1023));
            7:       return RADICAND_MAX ^ RADICAND_BITS'($urandom_range(0, 65535));
            8, 9:    return RADICAND_BITS'($urandom() >> $urandom_range(0, 31));
            default: return RADICAND_BITS'($urandom());
        endcase
    endfunction

    task automatic send_radicand(input logic [RADICAND_BITS-1:0] value,
                                 input logic [ROOT_BITS-1:0] expected);
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            radicand_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        radicand       <= value;
        radicand_valid <= 1'b1;
        do
            @(posedge clk);
        while (!radicand_ready);
        root_expected_q.push_back(expected);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && root_valid && root_ready)
        begin
            if (root_expected_q.size() == 0)
            begin
                $display("%0t: root %0d with no transaction pending", $time, root);
                error_count <= error_count + 1;
            end
            else
            begin
                if (root !== root_expected_q[0])
                begin
                    $display("%0t: root mismatch: expected %0d, actual %0d",
                             $time, root_expected_q[0], root);
                    error_count <= error_count + 1;
                end
                void'(root_expected_q.pop_front());
                roots_checked <= roots_checked + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((radicand_valid && radicand_ready) || (root_valid && root_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d roots outstanding",
                     $time, root_expected_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off_req && !hold_off_done)
            begin
                root_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
                hold_off_done = 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 3) == 0)
            begin
                root_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            root_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    initial
    begin
        logic [RADICAND_BITS-1:0] value;
        logic [ROOT_BITS-1:0]     expected;
        rst_n          = 1'b0;
        radicand_valid = 1'b0;
        radicand       = '0;
        root_ready     = 1'b0;
        error_count    = 0;
        roots_checked  = 0;
        idle_cycles    = 0;
        quiet_phase    = 1'b0;
        hold_off_req   = 1'b0;
        hold_off_done  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cases[i])
        begin
            value    = directed_cases[i].value;
            expected = directed_cases[i].known ? directed_cases[i].root : floor_root_of(value);
            send_radicand(value, expected);
        end

        hold_off_req = 1'b1;
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            if (n == RANDOM_COUNT - QUIET_COUNT)
                quiet_phase = 1'b1;
            value = pick_radicand();
            send_radicand(value, floor_root_of(value));
        end
        radicand_valid <= 1'b0;

        while (root_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d directed and %0d random radicands, %0d roots checked,",
                 DIRECTED_COUNT, RANDOM_COUNT, roots_checked);
        $display("with idle bursts on both sides and one %0d-cycle output hold-off.",
                 HOLD_OFF_LEN);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
